### rtl/rwmm_pkg.sv
// Package for the rolling window max/mean block.
// Shared widths, parameter defaults, the interval reset constant and divider request/response types.
// No dependencies.
`default_nettype none

package rwmm_pkg;

    localparam int TIME_W          = 16;
    localparam int SAMPLE_W        = 8;
    localparam int DIV_W           = 16;
    localparam int BUCKETS_DEF     = 65;
    localparam int BUCKET_MS_DEF   = 1000;
    localparam logic [TIME_W-1:0] INTERVAL_RESET = 16'd250;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### rtl/rwmm_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on rwmm_pkg for the operand width and request/response types.
`default_nettype none

module rwmm_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rwmm_pkg::div_req_t req,
    output rwmm_pkg::div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(rwmm_pkg::DIV_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(rwmm_pkg::DIV_W - 1);

    logic [rwmm_pkg::DIV_W-1:0] rem_reg;
    logic [rwmm_pkg::DIV_W-1:0] quo_reg;
    logic [rwmm_pkg::DIV_W-1:0] dvs_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [rwmm_pkg::DIV_W:0]   trial;
    logic [rwmm_pkg::DIV_W:0]   diff;
    logic                       fits;

    assign trial = {rem_reg, quo_reg[rwmm_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_LAST);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[rwmm_pkg::DIV_W-1:0] : trial[rwmm_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[rwmm_pkg::DIV_W-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;

endmodule

`default_nettype wire

### rtl/rolling_window_max_mean.sv
// Rolling window maximum and mean over a bucketed rate history; uses rwmm_pkg and rwmm_div.
// Sequence: evaluate, then straight to the result when the sample is not taken; when it is,
// time and bucket divides, bucket pick, read-modify-write, bucket walk, drain and the mean divide.
// Flow: one transaction in work at a time; the next is accepted only after the previous
// result has been loaded into the output register.
// Reset: asynchronous, clears control state; the bucket store reads as zero until written.
`default_nettype none

module rolling_window_max_mean #(
    parameter int BUCKETS   = rwmm_pkg::BUCKETS_DEF,
    parameter int BUCKET_MS = rwmm_pkg::BUCKET_MS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rwmm_pkg::TIME_W-1:0]   time_ms,
    input  wire logic [rwmm_pkg::SAMPLE_W-1:0] rate_sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               updated,
    output logic [rwmm_pkg::SAMPLE_W-1:0]      window_max,
    output logic [rwmm_pkg::SAMPLE_W-1:0]      window_mean,
    input  wire logic                          cfg_we,
    input  wire logic [rwmm_pkg::TIME_W-1:0]   cfg_wdata
);

    localparam int AW    = $clog2(BUCKETS);
    localparam int AWX   = AW + 1;
    localparam int SUM_W = $clog2(BUCKETS * 255 + 1);
    localparam int CNT_W = $clog2(BUCKETS + 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(BUCKETS - 1);
    localparam logic [AW:0]   PICK_LIMIT = AWX'(BUCKETS);

    localparam int RCP_W  = rwmm_pkg::TIME_W + 1;
    localparam int PROD_W = rwmm_pkg::TIME_W + RCP_W;
    localparam int TQ_SH  = rwmm_pkg::TIME_W + $clog2(BUCKET_MS);
    localparam int BQ_SH  = rwmm_pkg::TIME_W + $clog2(BUCKETS);
    localparam logic [RCP_W-1:0] TQ_RCP =
        RCP_W'(((64'd1 << TQ_SH) + 64'(BUCKET_MS - 1)) / 64'(BUCKET_MS));
    localparam logic [RCP_W-1:0] BQ_RCP =
        RCP_W'(((64'd1 << BQ_SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS));
    localparam logic [rwmm_pkg::TIME_W-1:0] BKT_DIV = rwmm_pkg::TIME_W'(BUCKETS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EVAL     = 4'd1;
    localparam logic [3:0] S_DIV_TIME = 4'd2;
    localparam logic [3:0] S_DIV_BKT  = 4'd3;
    localparam logic [3:0] S_READ     = 4'd4;
    localparam logic [3:0] S_MODIFY   = 4'd5;
    localparam logic [3:0] S_WALK     = 4'd6;
    localparam logic [3:0] S_DRAIN    = 4'd7;
    localparam logic [3:0] S_MEAN_GO  = 4'd8;
    localparam logic [3:0] S_DIV_MEAN = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;
    localparam logic [3:0] S_PICK     = 4'd11;

    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;

    logic [rwmm_pkg::TIME_W-1:0]    interval_reg;
    logic [rwmm_pkg::TIME_W-1:0]    time_reg;
    logic [rwmm_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [rwmm_pkg::TIME_W-1:0]    last_time_reg;
    logic [AW-1:0]                  last_bucket_reg;
    logic [AW-1:0]                  pick_reg;
    logic [AW-1:0]                  idx_reg;
    logic                           sampled_reg;

    logic [rwmm_pkg::TIME_W-1:0]    tq_reg;
    logic [rwmm_pkg::TIME_W-1:0]    bq_reg;
    logic [PROD_W-1:0]              tq_prod;
    logic [PROD_W-1:0]              tq_shift;
    logic [PROD_W-1:0]              bq_prod;
    logic [PROD_W-1:0]              bq_shift;
    logic [rwmm_pkg::TIME_W-1:0]    bkt_base;
    logic [rwmm_pkg::TIME_W-1:0]    pick_full;

    logic [rwmm_pkg::SAMPLE_W-1:0]  bucket_mem [BUCKETS];
    logic [BUCKETS-1:0]             valid_reg;
    logic [rwmm_pkg::SAMPLE_W-1:0]  rd_data_reg;
    logic                           rd_vld_reg;
    logic                           acc_en_reg;
    logic [AW-1:0]                  rd_addr;
    logic [rwmm_pkg::SAMPLE_W-1:0]  rd_value;
    logic [rwmm_pkg::SAMPLE_W-1:0]  wr_value;

    logic [rwmm_pkg::SAMPLE_W-1:0]  max_reg;
    logic [SUM_W-1:0]               sum_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [rwmm_pkg::SAMPLE_W-1:0]  mean_reg;
    logic [rwmm_pkg::SAMPLE_W-1:0]  held_max_reg;
    logic [rwmm_pkg::SAMPLE_W-1:0]  held_mean_reg;

    logic                           out_valid_reg;
    logic                           updated_reg;
    logic [rwmm_pkg::SAMPLE_W-1:0]  window_max_reg;
    logic [rwmm_pkg::SAMPLE_W-1:0]  window_mean_reg;

    logic [rwmm_pkg::TIME_W-1:0]    elapsed;
    logic                           take;
    logic                           out_load;
    rwmm_pkg::div_req_t             div_req;
    rwmm_pkg::div_rsp_t             div_rsp;

    rwmm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign elapsed  = time_reg - last_time_reg;
    assign take     = elapsed > interval_reg;
    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign rd_addr  = (state_reg == S_READ) ? pick_reg : idx_reg;
    assign rd_value = rd_vld_reg ? rd_data_reg : '0;
    assign wr_value = ((pick_reg == last_bucket_reg) && (rd_value >= sample_reg))
                      ? rd_value : sample_reg;

    assign tq_prod   = PROD_W'(time_reg) * PROD_W'(TQ_RCP);
    assign tq_shift  = tq_prod >> TQ_SH;
    assign bq_prod   = PROD_W'(tq_reg) * PROD_W'(BQ_RCP);
    assign bq_shift  = bq_prod >> BQ_SH;
    assign bkt_base  = bq_reg * BKT_DIV;
    assign pick_full = tq_reg - bkt_base;

    always_comb
    begin
        div_req.start    = (state_reg == S_MEAN_GO);
        div_req.dividend = rwmm_pkg::DIV_W'(sum_reg);
        div_req.divisor  = (cnt_reg == '0) ? rwmm_pkg::DIV_W'(1)
                                           : rwmm_pkg::DIV_W'(cnt_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     state_next = in_valid ? S_EVAL : S_IDLE;
            S_EVAL:     state_next = take ? S_DIV_TIME : S_DONE;
            S_DIV_TIME: state_next = S_DIV_BKT;
            S_DIV_BKT:  state_next = S_PICK;
            S_PICK:     state_next = S_READ;
            S_READ:     state_next = S_MODIFY;
            S_MODIFY:   state_next = S_WALK;
            S_WALK:     state_next = (idx_reg == IDX_LAST) ? S_DRAIN : S_WALK;
            S_DRAIN:    state_next = S_MEAN_GO;
            S_MEAN_GO:  state_next = S_DIV_MEAN;
            S_DIV_MEAN: state_next = div_rsp.done ? S_DONE : S_DIV_MEAN;
            S_DONE:     state_next = out_load ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            interval_reg    <= rwmm_pkg::INTERVAL_RESET;
            last_time_reg   <= '0;
            last_bucket_reg <= '0;
            held_max_reg    <= '0;
            held_mean_reg   <= '0;
            valid_reg       <= '0;
            acc_en_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_en_reg <= (state_reg == S_WALK);
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
            if (state_reg == S_MODIFY)
            begin
                valid_reg[pick_reg] <= 1'b1;
                last_bucket_reg     <= pick_reg;
                last_time_reg       <= time_reg;
            end
            if (out_load && sampled_reg)
            begin
                held_max_reg  <= max_reg;
                held_mean_reg <= mean_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MODIFY)
        begin
            bucket_mem[pick_reg] <= wr_value;
        end
        rd_data_reg <= bucket_mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            time_reg   <= time_ms;
            sample_reg <= rate_sample;
        end
        if (state_reg == S_EVAL)
        begin
            sampled_reg <= take;
        end
        if (state_reg == S_DIV_TIME)
        begin
            tq_reg <= tq_shift[rwmm_pkg::TIME_W-1:0];
        end
        if (state_reg == S_DIV_BKT)
        begin
            bq_reg <= bq_shift[rwmm_pkg::TIME_W-1:0];
        end
        if (state_reg == S_PICK)
        begin
            pick_reg <= pick_full[AW-1:0];
        end
        if (state_reg == S_MODIFY)
        begin
            idx_reg <= '0;
            max_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (state_reg == S_WALK)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (acc_en_reg)
            begin
                if (rd_value > max_reg)
                begin
                    max_reg <= rd_value;
                end
                sum_reg <= sum_reg + SUM_W'(rd_value);
                if (rd_value != '0)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
        if ((state_reg == S_DIV_MEAN) && div_rsp.done)
        begin
            mean_reg <= div_rsp.quotient[rwmm_pkg::SAMPLE_W-1:0];
        end
        if (out_load)
        begin
            updated_reg     <= sampled_reg;
            window_max_reg  <= sampled_reg ? max_reg : held_max_reg;
            window_mean_reg <= sampled_reg ? mean_reg : held_mean_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign updated     = updated_reg;
    assign window_max  = window_max_reg;
    assign window_mean = window_mean_reg;

`ifndef SYNTHESIS
    a_bucket_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MODIFY) |=> valid_reg[$past(pick_reg)])
        else $error("written bucket not marked valid");

    a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_MEAN))
        else $error("divider finished outside a divide step");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ({1'b0, pick_reg} < PICK_LIMIT))
        else $error("bucket index out of range");

    a_held_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !updated_reg)
            |-> (window_max_reg == held_max_reg && window_mean_reg == held_mean_reg))
        else $error("unsampled result differs from held statistics");
`endif

endmodule

`default_nettype wire
